/* src/tlpt_pkg.sv */
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types, codes and sizes for the two-level page table engine.
// ----------------------------------------------------------------------------
package tlpt_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int PAGE_BYTES    = 4096;
	localparam int DIR_SLOTS     = 4;
	localparam int TOTAL_ENTRIES = DIR_SLOTS * TABLE_ENTRIES;
	localparam int SLOT_W        = $clog2(TOTAL_ENTRIES);
	localparam int OFFSET_W      = $clog2(PAGE_BYTES);
	localparam int COUNT_W       = 21;

	localparam logic [31:0] FRAME_MASK = 32'hfffff000;

	// request function codes
	localparam logic [2:0] F_MAP    = 3'd0;
	localparam logic [2:0] F_RANGE  = 3'd1;
	localparam logic [2:0] F_TO_END = 3'd2;
	localparam logic [2:0] F_TRANS  = 3'd3;
	localparam logic [2:0] F_READ   = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_MISALIGNED = 2'd1;
	localparam logic [1:0] ST_END_BELOW  = 2'd2;
	localparam logic [1:0] ST_BEYOND     = 2'd3;

	// command kinds handed from front to back
	localparam logic [1:0] K_IMM   = 2'd0;
	localparam logic [1:0] K_RUN   = 2'd1;
	localparam logic [1:0] K_TRANS = 2'd2;
	localparam logic [1:0] K_READ  = 2'd3;

	typedef struct packed {
		logic [2:0]         func;
		logic [31:0]        virt_addr;
		logic [31:0]        phys_addr;
		logic [31:0]        phys_limit;
		logic [COUNT_W-1:0] page_count;
		logic [11:0]        entry_flags;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] result_word;
	} rsp_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         status;
		logic [31:0]        virt;
		logic [31:0]        phys;
		logic [COUNT_W-1:0] count;
		logic [11:0]        flags;
	} cmd_t;

	// directory index past the built slots
	function automatic logic beyond(input logic [31:0] va);
		return {1'b0, va[31:22]} >= 11'(DIR_SLOTS);
	endfunction

endpackage

/* src/tlpt_ram.sv */
// ----------------------------------------------------------------------------
// tlpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/tlpt_front.sv */
// ----------------------------------------------------------------------------
// tlpt_front
// Accepts requests, checks alignment and ranges, and queues commands for the
// back end in a two-entry queue.
// ----------------------------------------------------------------------------
module tlpt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  tlpt_pkg::req_t request,
	input  logic          init_busy,
	input  logic          cmd_pop,
	output logic          cmd_empty,
	output tlpt_pkg::cmd_t cmd_head
);
	import tlpt_pkg::*;

	cmd_t        cmd_new;
	cmd_t        slots_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        accept;
	logic        take;
	logic        va_ok;
	logic        pa_ok;
	logic        pe_ok;
	logic [31:0] span;

	assign va_ok = request.virt_addr[OFFSET_W-1:0] == '0;
	assign pa_ok = request.phys_addr[OFFSET_W-1:0] == '0;
	assign pe_ok = request.phys_limit[OFFSET_W-1:0] == '0;
	assign span  = request.phys_limit - request.phys_addr;

	always_comb begin
		cmd_new.kind   = K_IMM;
		cmd_new.status = ST_OK;
		cmd_new.virt   = request.virt_addr;
		cmd_new.phys   = request.phys_addr;
		cmd_new.count  = request.page_count;
		cmd_new.flags  = request.entry_flags;
		case (request.func)
			F_MAP: begin
				if (!va_ok || !pa_ok) begin
					cmd_new.status = ST_MISALIGNED;
				end else begin
					cmd_new.kind  = K_RUN;
					cmd_new.count = COUNT_W'(1);
				end
			end
			F_RANGE: begin
				// a run of zero pages is fine even when misaligned
				if (request.page_count == '0) begin
					cmd_new.status = ST_OK;
				end else if (!va_ok || !pa_ok) begin
					cmd_new.status = ST_MISALIGNED;
				end else begin
					cmd_new.kind = K_RUN;
				end
			end
			F_TO_END: begin
				if (!va_ok || !pa_ok || !pe_ok) begin
					cmd_new.status = ST_MISALIGNED;
				end else if (request.phys_limit < request.phys_addr) begin
					cmd_new.status = ST_END_BELOW;
				end else if (span[31:OFFSET_W] != '0) begin
					cmd_new.kind  = K_RUN;
					cmd_new.count = COUNT_W'(span[31:OFFSET_W]);
				end
			end
			F_TRANS: begin
				if (beyond(request.virt_addr)) begin
					cmd_new.status = ST_BEYOND;
				end else begin
					cmd_new.kind = K_TRANS;
				end
			end
			F_READ: begin
				if (!va_ok) begin
					cmd_new.status = ST_MISALIGNED;
				end else if (beyond(request.virt_addr)) begin
					cmd_new.status = ST_BEYOND;
				end else begin
					cmd_new.kind = K_READ;
				end
			end
			default: begin
				cmd_new.status = ST_OK;
			end
		endcase
	end

	assign full      = (cnt_q == 2'd2) || init_busy;
	assign accept    = push && !full;
	assign cmd_empty = cnt_q == 2'd0;
	assign take      = cmd_pop && !cmd_empty;
	assign cmd_head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			slots_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (accept && !take) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (take && !accept) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

/* src/tlpt_back.sv */
// ----------------------------------------------------------------------------
// tlpt_back
// Executes queued commands against the entry memory: page runs, reads and
// translations. Also runs the identity fill after reset.
// ----------------------------------------------------------------------------
module tlpt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_empty,
	input  tlpt_pkg::cmd_t cmd_head,
	output logic           cmd_pop,
	output logic           init_busy,
	output logic           empty,
	input  logic           pop,
	output tlpt_pkg::rsp_t response
);
	import tlpt_pkg::*;

	localparam logic [1:0] S_INIT = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_RUN  = 2'd2;
	localparam logic [1:0] S_READ = 2'd3;

	logic [1:0]          state_q;
	logic [SLOT_W-1:0]   init_cnt_q;
	logic [31:0]         virt_q;
	logic [31:0]         phys_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [11:0]         flags_q;
	logic [OFFSET_W-1:0] off_q;
	logic                trans_q;
	logic                res_valid_q;
	rsp_t                res_q;

	logic                res_free;
	logic                run_bad;
	logic                we;
	logic [SLOT_W-1:0]   waddr;
	logic [31:0]         wdata;
	logic [31:0]         rdata;

	assign res_free  = !res_valid_q || pop;
	assign cmd_pop   = (state_q == S_IDLE) && !cmd_empty && res_free;
	assign init_busy = state_q == S_INIT;
	assign empty     = !res_valid_q;
	assign response  = res_q;
	assign run_bad   = beyond(virt_q);

	always_comb begin
		if (state_q == S_INIT) begin
			we    = 1'b1;
			waddr = init_cnt_q;
			wdata = 32'(init_cnt_q) << OFFSET_W;
		end else begin
			we    = (state_q == S_RUN) && !run_bad;
			waddr = virt_q[OFFSET_W +: SLOT_W];
			wdata = phys_q | {20'b0, flags_q};
		end
	end

	tlpt_ram #(
		.WIDTH(32),
		.DEPTH(TOTAL_ENTRIES)
	) u_entries (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (cmd_head.virt[OFFSET_W +: SLOT_W]),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			virt_q  <= cmd_head.virt;
			phys_q  <= cmd_head.phys;
			cnt_q   <= cmd_head.count;
			flags_q <= cmd_head.flags;
			off_q   <= cmd_head.virt[OFFSET_W-1:0];
			trans_q <= cmd_head.kind == K_TRANS;
		end else if (state_q == S_RUN) begin
			virt_q <= virt_q + 32'(PAGE_BYTES);
			phys_q <= phys_q + 32'(PAGE_BYTES);
			cnt_q  <= cnt_q - COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_cnt_q  <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_cnt_q <= init_cnt_q + SLOT_W'(1);
					if (init_cnt_q == SLOT_W'(TOTAL_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_pop) begin
						case (cmd_head.kind)
							K_IMM: begin
								res_q.status      <= cmd_head.status;
								res_q.result_word <= '0;
								res_valid_q       <= 1'b1;
							end
							K_RUN: begin
								state_q <= S_RUN;
							end
							default: begin
								state_q <= S_READ;
							end
						endcase
					end
				end
				S_RUN: begin
					// run ends at its first bad page or after its last write
					if (run_bad) begin
						res_q.status      <= ST_BEYOND;
						res_q.result_word <= '0;
						res_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end else if (cnt_q == COUNT_W'(1)) begin
						res_q.status      <= ST_OK;
						res_q.result_word <= '0;
						res_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				S_READ: begin
					res_q.status <= ST_OK;
					if (trans_q) begin
						res_q.result_word <= (rdata & FRAME_MASK) + 32'(off_q);
					end else begin
						res_q.result_word <= rdata;
					end
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/two_level_page_table_engine_unit.sv */
// ----------------------------------------------------------------------------
// two_level_page_table_engine_unit
// Two-level page table (4 KiB pages) with map, translate and read requests.
// ----------------------------------------------------------------------------
// After reset the block fills the entry memory with the identity mapping, one
// entry per cycle, holding full high until all DIR_SLOTS * 1024 entries are
// written (4096 with the default of four directory slots). The front end
// classifies a request in the cycle it is taken and queues it (two commands
// deep); the back end owns the single write / single read entry memory. A
// request failing its checks is answered from idle; a map or run goes through
// the run state, one memory write per page, a translate or read through the
// read state. Requests still queue while a result waits in the output register.
module two_level_page_table_engine_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  tlpt_pkg::req_t request,
	output logic           empty,
	input  logic           pop,
	output tlpt_pkg::rsp_t response
);
	import tlpt_pkg::*;

	cmd_t cmd_head;
	logic cmd_empty;
	logic cmd_pop;
	logic init_busy;

	tlpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.init_busy (init_busy),
		.cmd_pop   (cmd_pop),
		.cmd_empty (cmd_empty),
		.cmd_head  (cmd_head)
	);

	tlpt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.init_busy (init_busy),
		.empty     (empty),
		.pop       (pop),
		.response  (response)
	);

endmodule

/* test/two_level_page_table_engine_unit_tb.sv */
// ----------------------------------------------------------------------------
// two_level_page_table_engine_unit_tb
// Map, translate and read requests checked against a page table held here.
// A short table of directed requests (reset contents, extremes, every error
// code, runs that wrap or run off the last slot) is followed by random
// requests biased toward aligned, in-range addresses. Both sides idle in
// random bursts; the result side also holds off for a long stretch.
// ----------------------------------------------------------------------------
module two_level_page_table_engine_unit_tb;
	import tlpt_pkg::*;

	localparam int RANDOM_ITEMS = 1200;
	localparam int CALM_ITEMS   = 150;
	localparam int HOLD_AT      = 300;
	localparam int DRAIN_AT     = 700;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 64;
	localparam int CYCLE_LIMIT  = 2_000_000;

	// function codes the block leaves unused
	localparam logic [2:0] F_SPARE_LO = 3'd5;
	localparam logic [2:0] F_SPARE_HI = 3'd7;

	typedef struct packed {
		req_t req;
		logic fixed;
		rsp_t rsp;
	} row_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic empty;
	logic pop;
	req_t request;
	rsp_t response;

	logic [31:0] page_mem [TOTAL_ENTRIES];
	rsp_t        due_rsp [$];
	row_t        dir_rows [$];

	int errors;
	int rsp_seen;
	int cycles;
	bit calm;
	bit hold_go;
	bit hold_rx;

	two_level_page_table_engine_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.empty    (empty),
		.pop      (pop),
		.response (response)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("two_level_page_table_engine_unit: mismatch");
			$finish;
		end
	end

	// ---- page table shadow ----

	function automatic bit slot_of(input logic [31:0] va, output int unsigned idx);
		idx = va[31:22] * TABLE_ENTRIES + va[21:12];
		return va[31:22] < DIR_SLOTS;
	endfunction

	function automatic logic [1:0] write_page(input logic [31:0] va, input logic [31:0] pa,
		input logic [11:0] fl);
		int unsigned idx;
		if (va[11:0] != 12'd0 || pa[11:0] != 12'd0)
			return ST_MISALIGNED;
		if (!slot_of(va, idx))
			return ST_BEYOND;
		page_mem[idx] = pa | {20'd0, fl};
		return ST_OK;
	endfunction

	// stops at the first failing page; earlier pages stay written
	function automatic logic [1:0] write_run(input logic [31:0] va, input logic [31:0] pa,
		input logic [31:0] cnt, input logic [11:0] fl);
		logic [1:0]  st;
		logic [31:0] n;
		for (n = 0; n < cnt; n++) begin
			st = write_page(va, pa, fl);
			if (st != ST_OK)
				return st;
			va += PAGE_BYTES;
			pa += PAGE_BYTES;
		end
		return ST_OK;
	endfunction

	function automatic rsp_t page_table_outcome(input req_t r);
		rsp_t        o;
		int unsigned idx;
		o = '0;
		case (r.func)
			F_MAP: begin
				o.status = write_page(r.virt_addr, r.phys_addr, r.entry_flags);
			end
			F_RANGE: begin
				o.status = write_run(r.virt_addr, r.phys_addr, 32'(r.page_count), r.entry_flags);
			end
			F_TO_END: begin
				if (r.virt_addr[11:0] != 12'd0 || r.phys_addr[11:0] != 12'd0 ||
				    r.phys_limit[11:0] != 12'd0)
					o.status = ST_MISALIGNED;
				else if (r.phys_limit < r.phys_addr)
					o.status = ST_END_BELOW;
				else
					o.status = write_run(r.virt_addr, r.phys_addr,
						(r.phys_limit - r.phys_addr) >> OFFSET_W, r.entry_flags);
			end
			F_TRANS: begin
				if (slot_of(r.virt_addr, idx))
					o.result_word = (page_mem[idx] & FRAME_MASK) + {20'd0, r.virt_addr[11:0]};
				else
					o.status = ST_BEYOND;
			end
			F_READ: begin
				if (r.virt_addr[11:0] != 12'd0)
					o.status = ST_MISALIGNED;
				else if (slot_of(r.virt_addr, idx))
					o.result_word = page_mem[idx];
				else
					o.status = ST_BEYOND;
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	// ---- driving ----

	task automatic flag_error(input string what);
		errors++;
		if (errors <= 10)
			$display("%s", what);
	endtask

	task automatic offer(input req_t r, input logic fixed, input rsp_t want);
		rsp_t calc;
		push    <= 1'b1;
		request <= r;
		do @(posedge clk); while (full !== 1'b0);
		calc = page_table_outcome(r);
		due_rsp.push_back(fixed ? want : calc);
	endtask

	task automatic table_row(input logic [2:0] fn, input logic [31:0] va, input logic [31:0] pa,
		input logic [31:0] pe, input logic [20:0] cnt, input logic [11:0] fl,
		input logic fixed, input logic [1:0] st, input logic [31:0] word);
		row_t rw;
		rw.req = '{func: fn, virt_addr: va, phys_addr: pa, phys_limit: pe,
			page_count: cnt, entry_flags: fl};
		rw.fixed = fixed;
		rw.rsp = '{status: st, result_word: word};
		dir_rows.push_back(rw);
	endtask

	task automatic idle_gap();
		if (!calm && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (due_rsp.size() != 0);
	endtask

	initial begin
		int          pick;
		logic [2:0]  fn;
		logic [31:0] va;
		logic [31:0] pa;
		logic [31:0] pe;
		logic [20:0] cnt;
		req_t        r;

		arst_n  <= 1'b0;
		push    <= 1'b0;
		request <= '0;
		for (int n = 0; n < TOTAL_ENTRIES; n++)
			page_mem[n] = n * PAGE_BYTES;

		// reset contents and extremes before anything is written
		table_row(F_READ,     32'h0000_0000, 0, 0, 0, 0, 1, ST_OK, 32'h0000_0000);
		table_row(F_READ,     32'h00FF_F000, 0, 0, 0, 0, 1, ST_OK, 32'h00FF_F000);
		table_row(F_TRANS,    32'h00AB_CDEF, 0, 0, 0, 0, 1, ST_OK, 32'h00AB_CDEF);
		table_row(F_TRANS,    32'h00FF_FFFF, 0, 0, 0, 0, 1, ST_OK, 32'h00FF_FFFF);
		table_row(F_TRANS,    32'hFFFF_FFFF, 0, 0, 0, 0, 1, ST_BEYOND, 0);
		table_row(F_READ,     32'hFFFF_FFFF, 0, 0, 0, 0, 1, ST_MISALIGNED, 0);
		table_row(F_READ,     32'h0100_0000, 0, 0, 0, 0, 1, ST_BEYOND, 0);
		// single page maps
		table_row(F_MAP,      32'h0000_1000, 32'hFFFF_F000, 0, 0, 12'hFFF, 1, ST_OK, 0);
		table_row(F_READ,     32'h0000_1000, 0, 0, 0, 0, 1, ST_OK, 32'hFFFF_FFFF);
		table_row(F_TRANS,    32'h0000_1ABC, 0, 0, 0, 0, 1, ST_OK, 32'hFFFF_FABC);
		table_row(F_MAP,      32'h0000_2001, 32'h0000_0000, 0, 0, 12'h001, 1, ST_MISALIGNED, 0);
		table_row(F_MAP,      32'h0000_2000, 32'h0000_0800, 0, 0, 12'h001, 1, ST_MISALIGNED, 0);
		table_row(F_MAP,      32'hFFFF_F000, 32'hFFFF_F000, 0, 0, 12'hFFF, 1, ST_BEYOND, 0);
		// runs: empty run ignores alignment; phys wraps; run falls off the last slot
		table_row(F_RANGE,    32'h0000_0001, 32'h0000_0001, 0, 0, 12'h000, 1, ST_OK, 0);
		table_row(F_RANGE,    32'h00FF_C000, 32'hFFFF_E000, 0, 8, 12'h005, 1, ST_BEYOND, 0);
		table_row(F_READ,     32'h00FF_E000, 0, 0, 0, 0, 0, ST_OK, 0);
		table_row(F_TO_END,   32'h0000_2000, 32'h0000_3000, 32'h0000_0010, 0, 0, 1,
			ST_MISALIGNED, 0);
		table_row(F_TO_END,   32'h0000_2000, 32'h0000_5000, 32'h0000_4000, 0, 0, 1,
			ST_END_BELOW, 0);
		table_row(F_TO_END,   32'h0000_2000, 32'h0000_5000, 32'h0000_5000, 0, 0, 1, ST_OK, 0);
		table_row(F_TO_END,   32'h0001_0000, 32'h0010_0000, 32'h0010_4000, 0, 12'h00A, 0,
			ST_OK, 0);
		table_row(F_TRANS,    32'h0001_3FFF, 0, 0, 0, 0, 0, ST_OK, 0);
		table_row(F_RANGE,    32'h0000_0000, 32'h8000_0000, 0, 21'h10_0000, 12'h003, 1,
			ST_BEYOND, 0);
		table_row(F_READ,     32'h00FF_F000, 0, 0, 0, 0, 0, ST_OK, 0);
		table_row(F_TO_END,   32'h0000_0000, 32'h0000_0000, 32'hFFFF_F000, 0, 12'h800, 1,
			ST_BEYOND, 0);
		table_row(F_READ,     32'h0040_0000, 0, 0, 0, 0, 0, ST_OK, 0);
		table_row(F_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 21'h1F_FFFF, 12'hFFF,
			1, ST_OK, 0);
		table_row(F_SPARE_HI, 32'h0000_1000, 0, 0, 0, 0, 1, ST_OK, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k]) begin
			offer(dir_rows[k].req, dir_rows[k].fixed, dir_rows[k].rsp);
			idle_gap();
		end
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == HOLD_AT)
				hold_go <= 1'b1;
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				calm <= 1'b1;

			pick = $urandom_range(0, 99);
			if (pick < 25)      fn = F_MAP;
			else if (pick < 40) fn = F_RANGE;
			else if (pick < 50) fn = F_TO_END;
			else if (pick < 75) fn = F_TRANS;
			else if (pick < 95) fn = F_READ;
			else                fn = 3'($urandom_range(F_SPARE_LO, F_SPARE_HI));

			// mostly aligned pages inside the built slots, with a small hot set
			pick = $urandom_range(0, 99);
			if (pick < 45)
				va = {10'($urandom_range(0, DIR_SLOTS - 1)), 10'($urandom_range(0, 31)), 12'd0};
			else if (pick < 75)
				va = {10'($urandom_range(0, DIR_SLOTS - 1)), 10'($urandom), 12'd0};
			else if (pick < 85)
				va = $urandom;
			else if (pick < 93)
				va = {10'($urandom_range(DIR_SLOTS, 1023)), 10'($urandom), 12'd0};
			else
				va = {10'($urandom_range(0, DIR_SLOTS - 1)), 10'($urandom),
					12'($urandom_range(1, 4095))};
			if (fn == F_TRANS && $urandom_range(0, 1) == 1)
				va[11:0] = 12'($urandom);

			pa = ($urandom_range(0, 99) < 85) ? ($urandom & FRAME_MASK) : $urandom;

			pick = $urandom_range(0, 99);
			if (pick < 75)      cnt = 21'($urandom_range(0, 16));
			else if (pick < 92) cnt = 21'($urandom_range(17, 300));
			else                cnt = 21'($urandom);

			pick = $urandom_range(0, 99);
			if (pick < 70)      pe = pa + ($urandom_range(0, 16) << OFFSET_W);
			else if (pick < 85) pe = pa - ($urandom_range(1, 16) << OFFSET_W);
			else                pe = $urandom;

			r = '{func: fn, virt_addr: va, phys_addr: pa, phys_limit: pe,
				page_count: cnt, entry_flags: 12'($urandom)};
			offer(r, 1'b0, '0);

			if (i == DRAIN_AT)
				drain();
			else
				idle_gap();
		end

		push <= 1'b0;
		while (due_rsp.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && due_rsp.size() == 0)
			$display("two_level_page_table_engine_unit: match");
		else
			$display("two_level_page_table_engine_unit: mismatch");
		$finish;
	end

	// long hold-off on the result side so the block backs up into full
	initial begin
		wait (hold_go);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// result side: check each popped item, then pick the next pop
	initial begin
		rsp_t want;
		int   stall;
		stall = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (due_rsp.size() == 0) begin
					flag_error($sformatf("%0t: result %0d with none expected: status %0d word %h",
						$realtime, rsp_seen, response.status, response.result_word));
				end else begin
					want = due_rsp.pop_front();
					if (response.status !== want.status ||
					    response.result_word !== want.result_word)
						flag_error($sformatf(
							"%0t: result %0d: status exp %0d got %0d, word exp %h got %h",
							$realtime, rsp_seen, want.status, response.status,
							want.result_word, response.result_word));
				end
				rsp_seen++;
			end
			if (hold_rx) begin
				pop <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				stall = $urandom_range(0, 17);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

endmodule

/* filelist.f */
src/tlpt_pkg.sv
src/tlpt_ram.sv
src/tlpt_front.sv
src/tlpt_back.sv
src/two_level_page_table_engine_unit.sv
test/two_level_page_table_engine_unit_tb.sv
